[hw/rtl/tekd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tekd_pkg
// Types and constants shared by the terminal escape key decoder.
// ----------------------------------------------------------------------------
package tekd_pkg;

   // Parser phases, one-hot
   typedef enum logic [3:0] {
      PH_IDLE    = 4'b0001,
      PH_ESC     = 4'b0010,
      PH_BRACKET = 4'b0100,
      PH_NUMBER  = 4'b1000
   } phase_type;

   // Event kinds on the result channel
   localparam logic [1:0] KIND_CLOSE = 2'd0;
   localparam logic [1:0] KIND_DOWN  = 2'd1;
   localparam logic [1:0] KIND_UP    = 2'd2;

   // Key codes
   localparam logic [8:0] KEY_RET = 9'd256;
   localparam logic [8:0] KEY_ESC = 9'd257;
   localparam logic [8:0] KEY_UP  = 9'd258;

   // Byte codes
   localparam logic [7:0] CH_CTRL_C = 8'h03;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_ESC    = 8'h1b;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LBRACK = 8'h5b;
   localparam logic [7:0] CH_TILDE  = 8'h7e;

   // Outcome of decoding one byte
   typedef struct packed {
      phase_type  nxt_phase;
      logic [7:0] nxt_accum;
      logic       emit_close;   // one close event
      logic       emit_press;   // key-down then key-up pair
      logic [8:0] key;
   } decode_type;

endpackage

[hw/rtl/tekd_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tekd_decode
// Combinational escape parser step: next phase, accumulator and events.
// ----------------------------------------------------------------------------
module tekd_decode (
   input  logic [7:0]           rx_byte,
   input  tekd_pkg::phase_type  phase,
   input  logic [7:0]           accum,
   output tekd_pkg::decode_type dec
);
   import tekd_pkg::*;

   logic        is_digit;
   logic        is_alnum;
   logic [3:0]  digit;
   logic [11:0] acc_sum;
   logic [8:0]  n9;

   assign is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
   assign is_alnum = is_digit || ((rx_byte >= 8'h41) && (rx_byte <= 8'h5a))
                     || ((rx_byte >= 8'h61) && (rx_byte <= 8'h7a));
   assign digit    = 4'(rx_byte - 8'h30);
   // value * 10 + digit
   assign acc_sum  = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0} + {8'h00, digit};
   assign n9       = {1'b0, accum};

   always_comb begin
      dec.nxt_phase  = phase;
      dec.nxt_accum  = accum;
      dec.emit_close = 1'b0;
      dec.emit_press = 1'b0;
      dec.key        = {1'b0, rx_byte};
      if (rx_byte == CH_CTRL_C) begin
         dec.nxt_phase  = PH_IDLE;
         dec.emit_close = 1'b1;
         dec.key        = 9'd0;
      end else if (rx_byte == CH_SPACE) begin
         dec.nxt_phase  = PH_IDLE;
         dec.emit_press = 1'b1;
      end else if (rx_byte == CH_CR) begin
         dec.nxt_phase  = PH_IDLE;
         dec.emit_press = 1'b1;
         dec.key        = KEY_RET;
      end else if (rx_byte == CH_ESC) begin
         // doubled escape emits the key and stays in escape
         dec.nxt_phase  = PH_ESC;
         dec.emit_press = (phase == PH_ESC);
         dec.key        = KEY_ESC;
      end else begin
         case (phase)
            PH_ESC: begin
               dec.nxt_phase = (rx_byte == CH_LBRACK) ? PH_BRACKET : PH_IDLE;
            end
            PH_BRACKET: begin
               dec.nxt_phase = PH_IDLE;
               if ((rx_byte >= 8'h41) && (rx_byte <= 8'h44)) begin
                  dec.emit_press = 1'b1;
                  dec.key        = KEY_UP + {7'd0, rx_byte[1:0] - 2'd1};
               end else if (is_digit) begin
                  dec.nxt_phase = PH_NUMBER;
                  dec.nxt_accum = {4'd0, digit};
               end
            end
            PH_NUMBER: begin
               if (is_digit) begin
                  dec.nxt_accum = (acc_sum > 12'd255) ? 8'hff : acc_sum[7:0];
               end else begin
                  dec.nxt_phase = PH_IDLE;
                  if (rx_byte == CH_TILDE) begin
                     if ((accum >= 8'd11) && (accum <= 8'd16)) begin
                        dec.emit_press = 1'b1;
                        dec.key        = n9 + 9'd251;
                     end else if ((accum >= 8'd17) && (accum <= 8'd21)) begin
                        dec.emit_press = 1'b1;
                        dec.key        = n9 + 9'd250;
                     end else if ((accum >= 8'd23) && (accum <= 8'd24)) begin
                        dec.emit_press = 1'b1;
                        dec.key        = n9 + 9'd249;
                     end
                  end
               end
            end
            default: begin
               // idle: alphanumerics press their own code
               dec.emit_press = is_alnum;
            end
         endcase
      end
   end

endmodule

[hw/rtl/terminal_escape_key_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder
// Turns a raw terminal byte stream into close and key press/release events.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one raw terminal byte per transaction (req_rx_byte).
//   rsp channel: one key event per transaction (kind, key id, run_end).
//   A byte yields no event, one close event (Ctrl-C) or a key-down/key-up
//   pair; run_end marks the last event that a byte causes.
//   Path: an accepted byte waits in the input register, where it is decoded;
//   its events are then loaded into the result register, which offers them.
//   Throughput: the result register delivers one event per cycle while
//   rsp_stall is low, so a byte that presses a key occupies it for a down
//   beat and an up beat; bytes with no event or a single close event pass
//   at one per cycle. A press keeps a later byte that emits waiting.
//   Stall: while rsp_stall is high the current event holds; the input
//   register holds its byte and req_stall rises unless the byte needs no
//   result slot. The next byte is taken as the last beat leaves.
//   Reset (synchronous, active high): parser returns to idle, accumulator
//   clears, both registers empty.
// ----------------------------------------------------------------------------
module terminal_escape_key_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_event_kind,
   output logic [8:0] rsp_key_id,
   output logic       rsp_run_end
);
   import tekd_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff, byte_in;

   // parser state
   phase_type  phase_ff, phase_in;
   logic [7:0] accum_ff, accum_in;

   // result register: one close event or a two-beat press
   logic       rec_valid_ff, rec_valid_in;
   logic       rec_close_ff, rec_close_in;
   logic [8:0] rec_key_ff, rec_key_in;
   logic       beat_ff, beat_in;

   decode_type dec;
   logic       rec_last;
   logic       rec_done;
   logic       dec_emits;
   logic       advance;

   tekd_decode u_decode (
      .rx_byte (byte_ff),
      .phase   (phase_ff),
      .accum   (accum_ff),
      .dec     (dec)
   );

   // close is a single beat, a press ends on its second beat
   assign rec_last  = rec_close_ff || beat_ff;
   assign rec_done  = rec_valid_ff && !rsp_stall && rec_last;
   assign dec_emits = dec.emit_close || dec.emit_press;

   // drain the input register when the byte needs no slot or the slot frees
   assign advance   = in_valid_ff && (!dec_emits || !rec_valid_ff || rec_done);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      byte_in     = byte_ff;
      if (advance || !in_valid_ff) begin
         in_valid_in = req_valid;
         byte_in     = req_rx_byte;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      if (advance) begin
         phase_in = dec.nxt_phase;
         accum_in = dec.nxt_accum;
      end
   end

   always_comb begin
      rec_valid_in = rec_valid_ff;
      rec_close_in = rec_close_ff;
      rec_key_in   = rec_key_ff;
      beat_in      = beat_ff;
      if (rec_valid_ff && !rsp_stall) begin
         // advance to the release beat, or retire
         if (rec_last) begin
            rec_valid_in = 1'b0;
            beat_in      = 1'b0;
         end else begin
            beat_in      = 1'b1;
         end
      end
      if (advance && dec_emits) begin
         rec_valid_in = 1'b1;
         rec_close_in = dec.emit_close;
         rec_key_in   = dec.key;
         beat_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= PH_IDLE;
         accum_ff     <= 8'd0;
         rec_valid_ff <= 1'b0;
         beat_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         accum_ff     <= accum_in;
         rec_valid_ff <= rec_valid_in;
         beat_ff      <= beat_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      rec_close_ff <= rec_close_in;
      rec_key_ff   <= rec_key_in;
   end

   // drive the result channel from the result register
   assign rsp_valid      = rec_valid_ff;
   assign rsp_key_id     = rec_key_ff;
   assign rsp_run_end    = rec_last;
   assign rsp_event_kind = rec_close_ff ? KIND_CLOSE : (beat_ff ? KIND_UP : KIND_DOWN);

`ifndef SYNTHESIS
   // a close event never has a second beat
   a_close_single: assert property (@(posedge clock) disable iff (reset)
      rec_valid_ff && beat_ff |-> !rec_close_ff)
      else $error("close event reached a second beat");

   // a key-down is always followed by its key-up with the same key
   a_press_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_end |=>
         rsp_valid && rsp_event_kind == KIND_UP && rsp_key_id == $past(rsp_key_id))
      else $error("key-down not followed by matching key-up");

   // a held byte stays in the input register until decoded
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(byte_ff))
      else $error("input register lost a byte");

   // the parser moves only when a byte is decoded
   a_phase_quiet: assert property (@(posedge clock) disable iff (reset)
      !$past(advance) && !$past(reset) |-> $stable(phase_ff) && $stable(accum_ff))
      else $error("parser state changed without a decoded byte");
`endif

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the terminal escape key decoder.
// A queue of raw terminal bytes (a directed opening, then mostly well-formed
// escape sequences with random content plus noise and broken sequences) feeds
// a clocked driver. Each accepted byte runs through a local copy of the
// escape parser, which queues the key events it should cause. A clocked
// monitor compares every event transaction, field by field, with the oldest
// queued event. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
   import tekd_pkg::*;

   // Byte and key codes not provided by the package
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_D = 8'h44;
   localparam logic [7:0] CH_UPPER_Z = 8'h5a;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7a;
   localparam logic [8:0] KEY_F1     = 9'd262;
   localparam logic [8:0] KEY_F6     = 9'd267;
   localparam logic [8:0] KEY_F11    = 9'd272;

   localparam int RANDOM_BYTES = 1400;
   localparam int QUIET_TAIL   = 150;    // last bytes run with no idling
   localparam int SETTLE       = 20;     // cycles to wait after the last event
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [1:0] kind;
      logic [8:0] key;
      logic       run_end;
   } key_event_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       drain_first;  // hold this byte until every event is out
   } rx_item_type;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [1:0] rsp_event_kind;
   logic [8:0] rsp_key_id;
   logic       rsp_run_end;

   terminal_escape_key_decoder DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_kind (rsp_event_kind),
      .rsp_key_id     (rsp_key_id),
      .rsp_run_end    (rsp_run_end)
   );

   rx_item_type   pending_bytes[$];
   key_event_type expected_events[$];

   // Shadow parser state
   phase_type  parse_phase  = PH_IDLE;
   logic [7:0] number_accum = 8'h00;

   int unsigned bytes_planned  = 0;
   int unsigned total_bytes    = 0;
   int unsigned bytes_taken    = 0;
   int unsigned events_checked = 0;
   int unsigned mismatches     = 0;
   int unsigned cycle_count    = 0;
   int unsigned send_gap       = 0;
   int unsigned stall_left     = 0;
   int unsigned n_close        = 0;
   int unsigned n_press        = 0;
   int unsigned n_fkey         = 0;
   int unsigned n_arrow        = 0;
   bit          drain_next     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Stimulus building
   // -------------------------------------------------------------------------

   // Append one byte; noise bytes do not count toward the planned total.
   task automatic queue_byte(input logic [7:0] b, input bit counted = 1'b1);
      pending_bytes.push_back('{rx_byte: b, drain_first: drain_next});
      drain_next = 1'b0;
      if (counted)
         bytes_planned++;
   endtask

   // Append the decimal digits of n, most significant first.
   task automatic queue_digits(input int unsigned n);
      int unsigned div;
      div = 1;
      while (div * 10 <= n)
         div *= 10;
      while (div > 0) begin
         queue_byte(CH_0 + 8'(n / div % 10));
         div /= 10;
      end
   endtask

   // ESC [ n ~ : a function key when n is in range, otherwise nothing
   task automatic queue_fkey(input int unsigned n, input bit lead_zero = 1'b0);
      queue_byte(CH_ESC);
      queue_byte(CH_LBRACK);
      if (lead_zero)
         queue_byte(CH_0);
      queue_digits(n);
      queue_byte(CH_TILDE);
   endtask

   function automatic logic [7:0] random_alnum();
      case ($urandom_range(0, 2))
         0:       return CH_0 + 8'($urandom_range(0, 9));
         1:       return CH_UPPER_A + 8'($urandom_range(0, 25));
         default: return CH_LOWER_A + 8'($urandom_range(0, 25));
      endcase
   endfunction

   function automatic logic [7:0] random_special();
      case ($urandom_range(0, 3))
         0:       return CH_CTRL_C;
         1:       return CH_SPACE;
         2:       return CH_CR;
         default: return CH_ESC;
      endcase
   endfunction

   // One random sequence: mostly well-formed, some broken, some noise.
   task automatic queue_random_sequence();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         // function key, mostly near the valid ranges, sometimes huge
         if ($urandom_range(0, 9) < 7)
            queue_fkey($urandom_range(10, 25), $urandom_range(0, 7) == 0);
         else
            queue_fkey($urandom_range(0, 9999), $urandom_range(0, 7) == 0);
      end else if (pick < 44) begin
         queue_byte(CH_ESC);
         queue_byte(CH_LBRACK);
         queue_byte(CH_UPPER_A + 8'($urandom_range(0, 3)));
      end else if (pick < 52) begin
         // doubled (or tripled) escape
         repeat ($urandom_range(2, 3)) queue_byte(CH_ESC);
      end else if (pick < 60) begin
         queue_byte(random_special());
      end else if (pick < 68) begin
         // sequence cut short by a byte that acts in every phase
         queue_byte(CH_ESC);
         if ($urandom_range(0, 1)) begin
            queue_byte(CH_LBRACK);
            if ($urandom_range(0, 1))
               queue_digits($urandom_range(0, 30));
         end
         queue_byte(random_special());
      end else if (pick < 80) begin
         queue_byte(random_alnum());
      end else if (pick < 90) begin
         // broken sequence ending in an arbitrary byte
         queue_byte(CH_ESC);
         if ($urandom_range(0, 2) != 0) begin
            queue_byte(CH_LBRACK);
            if ($urandom_range(0, 1))
               queue_digits($urandom_range(0, 300));
         end
         queue_byte(8'($urandom_range(0, 255)));
      end else begin
         queue_byte(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   // -------------------------------------------------------------------------
   // Event prediction
   // -------------------------------------------------------------------------

   function automatic bit is_digit(input logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   task automatic push_press(input logic [8:0] key);
      expected_events.push_back('{kind: KIND_DOWN, key: key, run_end: 1'b0});
      expected_events.push_back('{kind: KIND_UP, key: key, run_end: 1'b1});
      n_press++;
   endtask

   // Advance the shadow parser by one accepted byte and queue its events.
   task automatic decode_byte(input logic [7:0] c);
      phase_type   ph;
      logic [11:0] value;
      ph = parse_phase;
      if (c == CH_CTRL_C) begin
         parse_phase = PH_IDLE;
         expected_events.push_back('{kind: KIND_CLOSE, key: 9'd0, run_end: 1'b1});
         n_close++;
      end else if (c == CH_SPACE) begin
         parse_phase = PH_IDLE;
         push_press({1'b0, c});
      end else if (c == CH_CR) begin
         parse_phase = PH_IDLE;
         push_press(KEY_RET);
      end else if (c == CH_ESC) begin
         // a second escape is the escape key; the phase stays escape
         if (ph == PH_ESC)
            push_press(KEY_ESC);
         else
            parse_phase = PH_ESC;
      end else begin
         case (ph)
            PH_ESC: begin
               parse_phase = (c == CH_LBRACK) ? PH_BRACKET : PH_IDLE;
            end
            PH_BRACKET: begin
               parse_phase = PH_IDLE;
               if (c >= CH_UPPER_A && c <= CH_UPPER_D) begin
                  push_press(KEY_UP + 9'(c - CH_UPPER_A));
                  n_arrow++;
               end else if (is_digit(c)) begin
                  parse_phase  = PH_NUMBER;
                  number_accum = c - CH_0;
               end
            end
            PH_NUMBER: begin
               if (is_digit(c)) begin
                  // saturate the decimal value at 255
                  value        = 12'(number_accum) * 12'd10 + 12'(c - CH_0);
                  number_accum = (value > 12'd255) ? 8'd255 : value[7:0];
               end else begin
                  parse_phase = PH_IDLE;
                  if (c == CH_TILDE) begin
                     if (number_accum >= 8'd11 && number_accum <= 8'd16) begin
                        push_press(KEY_F1 + 9'(number_accum - 8'd11));
                        n_fkey++;
                     end else if (number_accum >= 8'd17 && number_accum <= 8'd21) begin
                        push_press(KEY_F6 + 9'(number_accum - 8'd17));
                        n_fkey++;
                     end else if (number_accum >= 8'd23 && number_accum <= 8'd24) begin
                        push_press(KEY_F11 + 9'(number_accum - 8'd23));
                        n_fkey++;
                     end
                  end
               end
            end
            default: begin
               if (is_digit(c) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                   (c >= CH_LOWER_A && c <= CH_LOWER_Z))
                  push_press({1'b0, c});
            end
         endcase
      end
   endtask

   // Idling runs in windows, leaving stretches without gaps, and stops for
   // the tail of the run.
   function automatic bit idling_on();
      if (bytes_taken + QUIET_TAIL >= total_bytes)
         return 1'b0;
      return (bytes_taken / 200) % 4 != 3;
   endfunction

   // -------------------------------------------------------------------------
   // Driver: present queued bytes, one transaction at a time
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : drive_bytes
      rx_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict as the byte is taken
         if (req_valid && !req_stall) begin
            decode_byte(req_rx_byte);
            bytes_taken++;
         end
         // a stalled byte holds; otherwise pick what comes next
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() == 0 ||
                         (pending_bytes[0].drain_first && expected_events.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               next_item   = pending_bytes.pop_front();
               req_valid   <= 1'b1;
               req_rx_byte <= next_item.rx_byte;
               if (idling_on() && $urandom_range(0, 5) == 0)
                  send_gap = $urandom_range(1, 14);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: random stall bursts and event checking
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : check_events
      key_event_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            events_checked++;
            if (expected_events.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("[%0t] unexpected event: kind=%0d key=%0d run_end=%0d",
                           $realtime, rsp_event_kind, rsp_key_id, rsp_run_end);
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_kind != want.kind || rsp_key_id != want.key ||
                   rsp_run_end != want.run_end) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display({"[%0t] event mismatch: expected kind=%0d key=%0d ",
                               "run_end=%0d, got kind=%0d key=%0d run_end=%0d"},
                              $realtime, want.kind, want.key, want.run_end,
                              rsp_event_kind, rsp_key_id, rsp_run_end);
               end
            end
         end
         // stall bursts are independent of rsp_valid so they land anywhere
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idling_on() && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Guard against a hung handshake
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d of %0d bytes taken, %0d events pending",
                  cycle_count, bytes_taken, total_bytes, expected_events.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sequence of the run
   // -------------------------------------------------------------------------
   initial begin
      // Directed opening: keys that act in every phase, idle alphanumerics,
      // a high byte, doubled and tripled escape, an arrow reached straight
      // from the escape phase, the first and last function keys, and a
      // saturated number that emits nothing.
      queue_byte(CH_CTRL_C);
      queue_byte(CH_SPACE);
      queue_byte(CH_CR);
      queue_byte(CH_UPPER_A);
      queue_byte(CH_LOWER_Z);
      queue_byte(8'hff);
      queue_byte(CH_ESC);
      queue_byte(CH_ESC);
      queue_byte(CH_ESC);
      queue_byte(CH_LBRACK);
      queue_byte(CH_UPPER_D);
      queue_fkey(11);
      queue_fkey(24);
      queue_fkey(999);
      queue_byte(CH_ESC);
      queue_byte(CH_CTRL_C);

      // Let the directed part drain completely before the random part.
      drain_next = 1'b1;
      while (bytes_planned < RANDOM_BYTES) begin
         queue_random_sequence();
         // one more full drain halfway through
         if (bytes_planned >= RANDOM_BYTES / 2 && bytes_planned < RANDOM_BYTES / 2 + 4)
            drain_next = 1'b1;
      end
      total_bytes = pending_bytes.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for every byte to be taken and every event to come out.
      while (pending_bytes.size() != 0 || req_valid || expected_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (expected_events.size() != 0) begin
         mismatches += expected_events.size();
         $display("%0d expected events never arrived", expected_events.size());
      end

      $display("Decoded %0d bytes into %0d events: %0d close, %0d key presses",
               bytes_taken, events_checked, n_close, n_press);
      $display("Of the presses, %0d arrow and %0d function keys; %0d mismatches",
               n_arrow, n_fkey, mismatches);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[files.f]
hw/rtl/tekd_pkg.sv
hw/rtl/tekd_decode.sv
hw/rtl/terminal_escape_key_decoder.sv
verif/tb_top.sv
